/* hdl/favl_pkg.sv */
// Shared types and codes for the append-only value log.
`timescale 1ns / 1ps
`default_nettype none

package favl_pkg;

  // operation codes carried in the func field
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] value;
  } favl_in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [5:0] slot;
    logic       erased;
  } favl_out_t;

  // update decision handed from the update logic to the top level
  typedef struct packed {
    logic wr_en;    // write back to the log memory
    logic advance;  // newest entry moves up by one
    logic wrap;     // store erased, newest entry back to 0
  } favl_upd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } favl_state_t;

endpackage : favl_pkg

`default_nettype wire

/* hdl/flash_append_value_log_unit.sv */
// Top level of the append-only value log: handshake, sequencer, memory and index.
// An accepted word passes through the EXEC state, then its result is registered.
// No new word is taken in EXEC: the log memory read of the newest entry is
//   followed there by its write-back.
// Reset (rst_n low, synchronous): newest index to 0, written flag cleared, both
//   channels idle. The memory is not swept; an unwritten newest entry reads as all ones.
`timescale 1ns / 1ps
`default_nettype none

module flash_append_value_log_unit
  import favl_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire favl_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output favl_out_t      out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [WIDTH-1:0] ONES = {WIDTH{1'b1}};

  // sequencer
  favl_state_t state_r, state_nxt;
  logic        rd_en;
  logic        in_fire;

  // item and index state
  favl_in_t        item_r;
  logic [IW-1:0]   newest_r, newest_nxt;
  logic            written_r, written_nxt;   // newest entry holds a programmed word
  logic            out_valid_r, out_valid_nxt;
  favl_out_t       out_data_r;

  // memory and update datapath
  logic [WIDTH-1:0] rd_data;
  logic [WIDTH-1:0] cur;
  logic [WIDTH-1:0] val;
  favl_upd_t        upd;
  logic [IW-1:0]    wr_addr;
  logic [WIDTH-1:0] wr_data;
  logic [WIDTH-1:0] new_val;
  logic             wr_en;

  assign in_fire = in_valid && in_ready;

  // IDLE takes a word only when the result register is free or draining,
  // so EXEC never finds the output occupied.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          rd_en     = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // word held for the EXEC cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  // Log memory: read the newest entry on accept, write back in EXEC.
  // Read and write of one word fall in different cycles, so no bypass.
  assign wr_en = (state_r == ST_EXEC) && upd.wr_en;

  favl_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (newest_r),
    .rd_data (rd_data)
  );

  // entry 0 before any write is erased; entries above newest are never read
  // before they are programmed, so no clearing pass is needed after a wrap
  assign cur = written_r ? rd_data : ONES;
  assign val = WIDTH'(item_r.value);

  favl_update #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_update (
    .func    (item_r.func),
    .val     (val),
    .cur     (cur),
    .newest  (newest_r),
    .ctl     (upd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .new_val (new_val)
  );

  always_comb begin
    newest_nxt  = newest_r;
    written_nxt = written_r;
    if (state_r == ST_EXEC) begin
      if (upd.wrap) begin
        newest_nxt = '0;
      end else if (upd.advance) begin
        newest_nxt = newest_r + IW'(1);
      end
      written_nxt = written_r | upd.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r  <= '0;
      written_r <= 1'b0;
    end else begin
      newest_r  <= newest_nxt;
      written_r <= written_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_data_r.read_value <= 8'(new_val);
      out_data_r.slot       <= 6'(newest_nxt);
      out_data_r.erased     <= upd.wrap;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks

  a_exec_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC)
  ) else $error("accepted word did not reach EXEC");

  a_exec_out_free: assert property (
    @(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> !out_valid_r
  ) else $error("EXEC found the result register occupied");

  a_result_from_exec: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC)
  ) else $error("result raised outside EXEC");

  a_wrap_slot_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.erased) |-> (out_data_r.slot == 6'd0)
  ) else $error("wrapped result does not point at entry 0");

  a_no_write_on_read: assert property (
    @(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EXEC) && (item_r.func == FUNC_READ)) |-> !wr_en
  ) else $error("read word wrote the log memory");

endmodule : flash_append_value_log_unit

`default_nettype wire

/* hdl/favl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module favl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : favl_ram

`default_nettype wire

/* hdl/favl_update.sv */
// Program/advance/wrap decision for one word against the newest entry.
`timescale 1ns / 1ps
`default_nettype none

module favl_update
  import favl_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     func,
  input  wire logic [WIDTH-1:0]         val,
  input  wire logic [WIDTH-1:0]         cur,
  input  wire logic [$clog2(DEPTH)-1:0] newest,
  output favl_upd_t                     ctl,
  output logic      [$clog2(DEPTH)-1:0] wr_addr,
  output logic      [WIDTH-1:0]         wr_data,
  output logic      [WIDTH-1:0]         new_val
);

  localparam int IW = $clog2(DEPTH);
  localparam logic [IW-1:0]    LAST = IW'(DEPTH - 1);
  localparam logic [WIDTH-1:0] ONES = {WIDTH{1'b1}};

  logic needs_set;

  // a 0-to-1 change cannot be programmed in place
  assign needs_set = |(val & ~cur);

  always_comb begin
    ctl     = '0;
    wr_addr = newest;
    wr_data = cur & val;
    new_val = cur;
    if (func == FUNC_WRITE) begin
      if (!needs_set) begin
        ctl.wr_en = 1'b1;
        new_val   = cur & val;
      end else if (newest == LAST) begin
        ctl.wr_en = 1'b1;
        ctl.wrap  = 1'b1;
        wr_addr   = '0;
        wr_data   = val;
        new_val   = val;
      end else if (val != ONES) begin
        // next entry is still erased, so programming leaves exactly val
        ctl.wr_en   = 1'b1;
        ctl.advance = 1'b1;
        wr_addr     = newest + IW'(1);
        wr_data     = val;
        new_val     = val;
      end
    end
  end

endmodule : favl_update

`default_nettype wire

/* bench/tb.sv */
// Self-checking bench for flash_append_value_log_unit: directed and random words
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import favl_pkg::*;

  localparam int         LOG_DEPTH  = 64;
  localparam logic [7:0] ERASED     = 8'hFF;
  localparam int         RAND_WORDS = 400;
  localparam int         DRAIN_CYC  = 8;   // idle wait after the last result is checked

  // Shadow of the log: cells, newest slot and the results still owed by the block.
  class value_log_tracker;
    logic [7:0] cells [LOG_DEPTH];
    int         newest_slot;
    favl_out_t  awaited_results [$];
    int         errors;

    function void clear();
      foreach (cells[i]) cells[i] = ERASED;
      newest_slot = 0;
      errors = 0;
      awaited_results.delete();
    endfunction

    function logic [7:0] newest_value();
      return cells[newest_slot];
    endfunction

    // Flash rules: programming only clears bits, so a cell takes old AND new.
    function favl_out_t apply_op(favl_in_t w);
      favl_out_t  r;
      logic [7:0] cur;
      logic       wrapped;
      wrapped = 1'b0;
      if (w.func == FUNC_WRITE) begin
        cur = cells[newest_slot];
        if ((w.value & ~cur) == 8'h00) begin
          // no bit needs to go back to one: reprogram in place
          cells[newest_slot] = cur & w.value;
        end else if (newest_slot + 1 >= LOG_DEPTH) begin
          // out of cells: erase everything, restart at cell 0
          foreach (cells[i]) cells[i] = ERASED;
          cells[0] = w.value;
          newest_slot = 0;
          wrapped = 1'b1;
        end else begin
          cells[newest_slot + 1] &= w.value;
          // an all-ones write leaves the fresh cell erased, so newest stays put
          if (cells[newest_slot + 1] != ERASED) newest_slot++;
        end
      end
      r.read_value = cells[newest_slot];
      r.slot       = newest_slot[5:0];
      r.erased     = wrapped;
      return r;
    endfunction

    function void note_word(favl_in_t w);
      awaited_results.push_back(apply_op(w));
    endfunction

    function void check_word(favl_out_t got);
      favl_out_t exp;
      if (awaited_results.size() == 0) begin
        $error("result word with nothing awaited: %h", got);
        errors++;
        return;
      end
      exp = awaited_results.pop_front();
      if (got.read_value !== exp.read_value) begin
        $error("read_value: expected %0h, got %0h", exp.read_value, got.read_value);
        errors++;
      end
      if (got.slot !== exp.slot) begin
        $error("slot: expected %0d, got %0d", exp.slot, got.slot);
        errors++;
      end
      if (got.erased !== exp.erased) begin
        $error("erased: expected %0b, got %0b", exp.erased, got.erased);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  favl_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  favl_out_t out_data;

  value_log_tracker tracker;

  // receiver stall pattern: an 8-bit mask, renewed each time mask_age reaches its top value
  logic [7:0] ready_mask  = 8'hFF;
  logic [2:0] ready_phase = '0;
  logic [4:0] mask_age    = '0;

  // sender burst bookkeeping
  int burst_left;

  flash_append_value_log_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Receiver: samples the handshake at the edge, then sets up ready for the
  // next cycle. Some windows never stall; others follow a random mask that
  // always has at least one ready bit, so a stall spans at most the tail of
  // one mask running into the head of the next.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_word(out_data);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready   <= ready_mask[ready_phase];
      ready_phase <= ready_phase + 3'd1;
      mask_age    <= mask_age + 5'd1;
      if (mask_age == 5'd31) begin
        if ($urandom_range(0, 3) == 0) ready_mask <= 8'hFF;
        else ready_mask <= 8'($urandom) | (8'h01 << $urandom_range(0, 7));
      end
    end
  end

  // Hold the word on the channel until taken, then book its expected result.
  // Valid is never dropped here; the caller decides whether a gap follows.
  task automatic send_word(input favl_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    tracker.note_word(w);
  endtask

  // Sender pacing: bursts of random length, random gaps between them.
  task automatic pace_sender();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  function automatic favl_in_t mk_word(input logic f, input logic [7:0] v);
    favl_in_t w;
    w.func  = f;
    w.value = v;
    return w;
  endfunction

  // Random word shaped by the current shadow state: plenty of in-place
  // rewrites (subsets of the newest value), plenty of advancing writes, and
  // extra all-ones writes on the last cell to hit the erase-and-wrap corner.
  function automatic favl_in_t pick_word();
    int         roll;
    logic [7:0] cur;
    cur  = tracker.newest_value();
    roll = $urandom_range(0, 99);
    if (tracker.newest_slot == LOG_DEPTH - 1 && $urandom_range(0, 3) == 0)
      return mk_word(FUNC_WRITE, ERASED);
    if (roll < 15) return mk_word(FUNC_READ, 8'($urandom));
    if (roll < 40) return mk_word(FUNC_WRITE, cur & 8'($urandom));
    if (roll < 45) return mk_word(FUNC_WRITE, ERASED);
    if (roll < 50) return mk_word(FUNC_WRITE, 8'h00);
    return mk_word(FUNC_WRITE, 8'($urandom));
  endfunction

  initial begin
    favl_in_t directed [$];
    tracker = new;
    tracker.clear();
    burst_left = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: read of the erased log, all-ones write onto the
    // erased log (no change), in-place narrowing, advance, all-ones write to
    // a fresh cell (newest stays), zero writes, then all bits both ways.
    directed = '{
      mk_word(FUNC_READ,  8'h00),
      mk_word(FUNC_WRITE, 8'hFF),
      mk_word(FUNC_READ,  8'hFF),
      mk_word(FUNC_WRITE, 8'hA5),
      mk_word(FUNC_WRITE, 8'h81),
      mk_word(FUNC_WRITE, 8'h7E),
      mk_word(FUNC_WRITE, 8'hFF),
      mk_word(FUNC_READ,  8'h5A),
      mk_word(FUNC_WRITE, 8'h00),
      mk_word(FUNC_WRITE, 8'h00),
      mk_word(FUNC_WRITE, 8'h01),
      mk_word(FUNC_WRITE, 8'h80),
      mk_word(FUNC_WRITE, 8'h55),
      mk_word(FUNC_WRITE, 8'hAA),
      mk_word(FUNC_WRITE, 8'hFE),
      mk_word(FUNC_WRITE, 8'h7F),
      mk_word(FUNC_READ,  8'h00)
    };
    foreach (directed[i]) begin
      pace_sender();
      send_word(directed[i]);
    end

    // Random part; each word is drawn only once the previous one is booked,
    // so the shadow state it is shaped from is current.
    repeat (RAND_WORDS) begin
      pace_sender();
      send_word(pick_word());
    end
    in_valid <= 1'b0;

    while (tracker.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (tracker.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/favl_pkg.sv
hdl/favl_ram.sv
hdl/favl_update.sv
hdl/flash_append_value_log_unit.sv
bench/tb.sv
